// ===== hw/rtl/lsps_pkg.sv =====
// lsps_pkg: shared widths, reset values, register codes and the stage struct
// for the line sensor pid steering block
// no dependencies
`timescale 1ns / 1ps

package lsps_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int THRESH_W   = 10;
   localparam int GAIN_W     = 8;
   localparam int ERROR_W    = 3;
   localparam int DIFF_W     = 4;
   localparam int DRIVE_W    = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int DRIVE_MAX = 8388607;
   localparam int DRIVE_MIN = -8388608;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd500;
   localparam logic [GAIN_W-1:0]   GAIN_P_RESET = 8'd35;
   localparam logic [GAIN_W-1:0]   GAIN_I_RESET = 8'd15;
   localparam logic [GAIN_W-1:0]   GAIN_D_RESET = 8'd5;

   // register index, byte address is 4 times this
   typedef enum logic [1:0] {
      REG_LINE_THRESHOLD = 2'd0,
      REG_GAIN_P         = 2'd1,
      REG_GAIN_I         = 2'd2,
      REG_GAIN_D         = 2'd3
   } csr_index_type;

   // error mapping result for one sample set
   typedef struct packed {
      logic signed [ERROR_W-1:0] steer_error;
      logic                      all_off_line;
   } pattern_type;

endpackage

// ===== hw/rtl/lsps_req_if.sv =====
// lsps_req_if: input item channel, three raw sensor samples
// depends on lsps_pkg
`timescale 1ns / 1ps

interface lsps_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsps_pkg::SAMPLE_W-1:0] left_sample;
   logic [lsps_pkg::SAMPLE_W-1:0] middle_sample;
   logic [lsps_pkg::SAMPLE_W-1:0] right_sample;

   modport source (output valid, output left_sample, output middle_sample,
                   output right_sample, input ready);
   modport sink   (input valid, input left_sample, input middle_sample,
                   input right_sample, output ready);
endinterface

// ===== hw/rtl/lsps_rsp_if.sv =====
// lsps_rsp_if: result item channel, drive value, error and all-off flag
// depends on lsps_pkg
`timescale 1ns / 1ps

interface lsps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lsps_pkg::DRIVE_W-1:0] drive_value;
   logic signed [lsps_pkg::ERROR_W-1:0] steer_error;
   logic                                all_off_line;

   modport source (output valid, output drive_value, output steer_error,
                   output all_off_line, input ready);
   modport sink   (input valid, input drive_value, input steer_error,
                   input all_off_line, output ready);
endinterface

// ===== hw/rtl/line_sensor_pid_steering.sv =====
// line_sensor_pid_steering: three-sensor line detector with pid steering output
// depends on lsps_pkg, lsps_req_if, lsps_rsp_if
`timescale 1ns / 1ps
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------------
//   req_chan  | in        | valid/ready        | left, middle, right sample
//   rsp_chan  | out       | valid/ready        | drive value, steer error, all off
//   csr (apb) | in        | psel/penable/write | threshold, gain p, gain i, gain d
//
// one item per cycle sustained while the result sink keeps taking; three register stages
// (sample, error/sum, drive) carry each accepted item to the result register
// the integral product and the drive clamp set the stage c path
// reset (synchronous, high) clears pipeline valids, error sum and last error,
// and loads the register reset values
// a stalled result holds in the output register; stages behind it keep filling
// until each holds an item, then req ready drops

module line_sensor_pid_steering #(
   parameter int SUM_WIDTH   = 16,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   lsps_req_if.sink                         req_chan,
   lsps_rsp_if.source                       rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lsps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lsps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lsps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import lsps_pkg::*;

   // accumulator width for the drive sum, wide enough for all three products
   localparam int AW = (SUM_WIDTH + 11 > 26) ? SUM_WIDTH + 11 : 26;
   // only the low SAMPLE_BITS bits of a sample take part in the compare
   localparam int MASK_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << MASK_BITS) - 64'd1);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [THRESH_W-1:0] threshold_ff;
   logic [GAIN_W-1:0]   gain_p_ff;
   logic [GAIN_W-1:0]   gain_i_ff;
   logic [GAIN_W-1:0]   gain_d_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LINE_THRESHOLD: threshold_ff <= pwdata[THRESH_W-1:0];
            REG_GAIN_P:         gain_p_ff    <= pwdata[GAIN_W-1:0];
            REG_GAIN_I:         gain_i_ff    <= pwdata[GAIN_W-1:0];
            REG_GAIN_D:         gain_d_ff    <= pwdata[GAIN_W-1:0];
            default:            ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_index)
         REG_LINE_THRESHOLD: prdata = CSR_DATA_W'(threshold_ff);
         REG_GAIN_P:         prdata = CSR_DATA_W'(gain_p_ff);
         REG_GAIN_I:         prdata = CSR_DATA_W'(gain_i_ff);
         REG_GAIN_D:         prdata = CSR_DATA_W'(gain_d_ff);
         default:            prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline flow control: a stage loads when it is empty or its item moves on
   // ------------------------------------------------------------------
   logic valid_a_ff, valid_b_ff, valid_c_ff;
   logic ready_a, ready_b, ready_c;
   logic load_a, load_b, load_c;

   assign ready_c = ~valid_c_ff | rsp_chan.ready;
   assign ready_b = ~valid_b_ff | ready_c;
   assign ready_a = ~valid_a_ff | ready_b;

   assign req_chan.ready = ready_a;
   assign load_a = req_chan.valid & ready_a;
   assign load_b = valid_a_ff & ready_b;
   assign load_c = valid_b_ff & ready_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= req_chan.valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
         if (ready_c) valid_c_ff <= valid_b_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage a: sample input register
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] left_a_ff, middle_a_ff, right_a_ff;

   always_ff @(posedge clock) begin
      if (load_a) begin
         left_a_ff   <= req_chan.left_sample;
         middle_a_ff <= req_chan.middle_sample;
         right_a_ff  <= req_chan.right_sample;
      end
   end

   // ------------------------------------------------------------------
   // stage b: line pattern, error, saturating integral, error change
   // ------------------------------------------------------------------
   logic                        on_left, on_middle, on_right;
   pattern_type                 pattern;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_in;
   logic signed [DIFF_W-1:0]    diff_in;

   logic signed [SUM_WIDTH-1:0] error_sum_ff;
   logic signed [ERROR_W-1:0]   prev_error_ff;

   logic signed [ERROR_W-1:0]   error_b_ff;
   logic signed [SUM_WIDTH-1:0] sum_b_ff;
   logic signed [DIFF_W-1:0]    diff_b_ff;
   logic                        off_b_ff;

   // on the line means strictly below the threshold
   assign on_left   = (left_a_ff   & SAMPLE_MASK) < threshold_ff;
   assign on_middle = (middle_a_ff & SAMPLE_MASK) < threshold_ff;
   assign on_right  = (right_a_ff  & SAMPLE_MASK) < threshold_ff;

   // left wins over right; middle only softens the error
   always_comb begin
      pattern.all_off_line = ~on_left & ~on_middle & ~on_right;
      if (on_left) begin
         pattern.steer_error = on_middle ? 3'sd1 : 3'sd2;
      end else if (on_right) begin
         pattern.steer_error = on_middle ? -3'sd1 : -3'sd2;
      end else begin
         pattern.steer_error = 3'sd0;
      end
   end

   // one extra bit catches overflow; clamp to the signed sum bounds
   always_comb begin
      sum_wide = (SUM_WIDTH + 1)'(error_sum_ff) + (SUM_WIDTH + 1)'(pattern.steer_error);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_in = {sum_wide[SUM_WIDTH], {(SUM_WIDTH - 1){~sum_wide[SUM_WIDTH]}}};
      end else begin
         sum_in = sum_wide[SUM_WIDTH-1:0];
      end
   end

   assign diff_in = DIFF_W'(pattern.steer_error) - DIFF_W'(prev_error_ff);

   // controller state moves only as an item enters stage b
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
      end else if (load_b) begin
         error_sum_ff  <= sum_in;
         prev_error_ff <= pattern.steer_error;
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         error_b_ff <= pattern.steer_error;
         sum_b_ff   <= sum_in;
         diff_b_ff  <= diff_in;
         off_b_ff   <= pattern.all_off_line;
      end
   end

   // ------------------------------------------------------------------
   // stage c: three gain products, sum, clamp to 24 bits
   // ------------------------------------------------------------------
   logic signed [GAIN_W:0]         gain_p_s, gain_i_s, gain_d_s;
   logic signed [GAIN_W+ERROR_W:0] prod_p;
   logic signed [GAIN_W+DIFF_W:0]  prod_d;
   logic signed [SUM_WIDTH+GAIN_W:0] prod_i;
   logic signed [AW-1:0]           drive_total;
   logic signed [DRIVE_W-1:0]      drive_in;

   logic signed [DRIVE_W-1:0]      drive_c_ff;
   logic signed [ERROR_W-1:0]      error_c_ff;
   logic                           off_c_ff;

   assign gain_p_s = signed'({1'b0, gain_p_ff});
   assign gain_i_s = signed'({1'b0, gain_i_ff});
   assign gain_d_s = signed'({1'b0, gain_d_ff});

   assign prod_p = gain_p_s * (GAIN_W + ERROR_W + 1)'(error_b_ff);
   assign prod_d = gain_d_s * (GAIN_W + DIFF_W + 1)'(diff_b_ff);
   assign prod_i = gain_i_s * (SUM_WIDTH + GAIN_W + 1)'(sum_b_ff);

   always_comb begin
      drive_total = AW'(prod_p) + AW'(prod_i) + AW'(prod_d);
      if (drive_total > AW'(DRIVE_MAX)) begin
         drive_in = DRIVE_W'(DRIVE_MAX);
      end else if (drive_total < AW'(DRIVE_MIN)) begin
         drive_in = DRIVE_W'(DRIVE_MIN);
      end else begin
         drive_in = drive_total[DRIVE_W-1:0];
      end
   end

   // result register, holds while the sink stalls
   always_ff @(posedge clock) begin
      if (load_c) begin
         drive_c_ff <= drive_in;
         error_c_ff <= error_b_ff;
         off_c_ff   <= off_b_ff;
      end
   end

   assign rsp_chan.valid        = valid_c_ff;
   assign rsp_chan.drive_value  = drive_c_ff;
   assign rsp_chan.steer_error  = error_c_ff;
   assign rsp_chan.all_off_line = off_c_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // the integral moves only when an item enters stage b
   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      !load_b |=> $stable(error_sum_ff))
      else $error("error sum changed without an item");

   // last error tracks the item just loaded into stage b
   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      load_b |=> (prev_error_ff == error_b_ff) && (error_sum_ff == sum_b_ff))
      else $error("controller state out of step with stage b");

   // steering error stays within -2..2
   a_error_range: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> (error_b_ff != 3'sd3) && (error_b_ff != -3'sd3)
                     && (error_b_ff != -3'sd4))
      else $error("steer error out of range");

   // no sensor on the line means zero error
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_b_ff && off_b_ff) |-> (error_b_ff == 3'sd0))
      else $error("all off with nonzero error");

   // a result that is not taken stays in the output register
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_c_ff && !rsp_chan.ready) |=> valid_c_ff && $stable(drive_c_ff))
      else $error("stalled result lost");

endmodule
